// ===== rtl/lfmcd_pkg.sv =====
package lfmcd_pkg;

  // default geometry of the frame parser
  localparam int FRAME_MAX_DEF   = 32;
  localparam int DATA_OFFSET_DEF = 2;
  localparam int ID_OFFSET_DEF   = 0;
  localparam int SLOT_COUNT_DEF  = 4;

  // fixed field widths
  localparam int BYTE_W = 8;
  localparam int POS_W  = 6;
  localparam int OFS_W  = 5;
  localparam int CIDX_W = 8;

  // configuration register indexes
  typedef enum logic [CIDX_W-1:0] {
    REG_END_BYTE      = 8'd0,
    REG_MOTOR_SLOT_ID = 8'd1,
    REG_LEFT_OFFSET   = 8'd2,
    REG_RIGHT_OFFSET  = 8'd3
  } cfg_reg_t;

  // parser positions with a fixed meaning
  localparam logic [POS_W-1:0] POS_START = 6'd0;
  localparam logic [POS_W-1:0] POS_SIZE  = 6'd1;
  localparam logic [POS_W-1:0] POS_BODY  = 6'd2;

  // reset values of the offset registers
  localparam logic [OFS_W-1:0] LEFT_OFFSET_RST  = 5'd1;
  localparam logic [OFS_W-1:0] RIGHT_OFFSET_RST = 5'd2;

endpackage

// ===== rtl/length_framed_motor_command_deframer.sv =====
// a result is registered when its frame's closing byte is accepted
// throughput: one byte per cycle while the skid is empty; a two-entry output queue
//   (result plus skid register) lets bytes flow on while one result waits to be taken
// reset (synchronous, rst_n low): parser back to frame start, frame store reads
//   as zero through per-entry valid bits, offsets to 1 and 2, queue empty
module length_framed_motor_command_deframer #(
  parameter int FRAME_MAX   = lfmcd_pkg::FRAME_MAX_DEF,
  parameter int DATA_OFFSET = lfmcd_pkg::DATA_OFFSET_DEF,
  parameter int ID_OFFSET   = lfmcd_pkg::ID_OFFSET_DEF,
  parameter int SLOT_COUNT  = lfmcd_pkg::SLOT_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lfmcd_pkg::BYTE_W-1:0]  in_rx_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lfmcd_pkg::BYTE_W-1:0]  out_left_drive,
  output logic [lfmcd_pkg::BYTE_W-1:0]  out_right_drive,
  input  logic                          cfg_we,
  input  logic [lfmcd_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [lfmcd_pkg::BYTE_W-1:0]  cfg_wdata
);

  localparam int STORE_DEPTH = FRAME_MAX + 1;
  localparam int AW          = $clog2(STORE_DEPTH);
  localparam int RA_RAW      = $clog2(DATA_OFFSET + 32);
  localparam int RA_W        = (RA_RAW > AW) ? RA_RAW : AW;
  localparam int ID_IDX      = DATA_OFFSET + ID_OFFSET;
  localparam bit ID_IN       = (ID_IDX < STORE_DEPTH);
  localparam int PW          = lfmcd_pkg::POS_W;
  localparam int BW          = lfmcd_pkg::BYTE_W;
  localparam int OW          = lfmcd_pkg::OFS_W;

  // configuration registers
  logic [BW-1:0] end_byte_r, end_byte_nxt;
  logic [BW-1:0] slot_id_r, slot_id_nxt;
  logic [OW-1:0] left_ofs_r, left_ofs_nxt;
  logic [OW-1:0] right_ofs_r, right_ofs_nxt;

  // parser state
  logic [PW-1:0] pos_r, pos_nxt;
  logic [BW-1:0] size_r, size_nxt;
  logic [BW-1:0] id_r, id_nxt;

  // frame store
  logic [BW-1:0]          mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] valid_r;

  // registered store reads for the drive bytes
  logic [BW-1:0] rd_l_raw_r, rd_r_raw_r, wdat_r;
  logic          byp_l_r, byp_r_r, vld_l_r, vld_r_r, oor_l_r, oor_r_r;
  logic [BW-1:0] left_byte, right_byte;

  // output queue
  logic          out_v_r, skid_v_r;
  logic [BW-1:0] out_l_r, out_rt_r, skid_l_r, skid_rt_r;

  logic          accept, pop, close, hit, push, wr_en;
  logic [AW-1:0] wr_idx;
  logic [RA_W-1:0] ra_l, ra_r;
  logic          ra_l_oor, ra_r_oor;

  // configuration write decode
  always_comb begin
    end_byte_nxt  = end_byte_r;
    slot_id_nxt   = slot_id_r;
    left_ofs_nxt  = left_ofs_r;
    right_ofs_nxt = right_ofs_r;
    if (cfg_we) begin
      unique case (cfg_index)
        lfmcd_pkg::REG_END_BYTE:      end_byte_nxt  = cfg_wdata;
        lfmcd_pkg::REG_MOTOR_SLOT_ID: slot_id_nxt   = cfg_wdata;
        lfmcd_pkg::REG_LEFT_OFFSET:   left_ofs_nxt  = cfg_wdata[OW-1:0];
        lfmcd_pkg::REG_RIGHT_OFFSET:  right_ofs_nxt = cfg_wdata[OW-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready = !skid_v_r;
  assign accept   = in_valid && in_ready;
  assign pop      = out_v_r && out_ready;

  // closing rule on a body byte
  assign close = (pos_r >= lfmcd_pkg::POS_BODY)
              && ({2'b00, pos_r} + 8'd1 >= size_r)
              && (in_rx_byte == end_byte_r);

  assign hit  = ({1'b0, id_r} < 9'(SLOT_COUNT)) && (id_r == slot_id_r);
  assign push = accept && close && hit;

  assign wr_en  = accept && (pos_r >= lfmcd_pkg::POS_BODY) && !close
               && (32'(pos_r) <= FRAME_MAX);
  assign wr_idx = pos_r[AW-1:0];

  // parser next state
  always_comb begin
    pos_nxt  = pos_r;
    size_nxt = size_r;
    id_nxt   = id_r;
    if (accept) begin
      if (pos_r == lfmcd_pkg::POS_START) begin
        pos_nxt = lfmcd_pkg::POS_SIZE;
      end else if (pos_r == lfmcd_pkg::POS_SIZE) begin
        if (32'(in_rx_byte) > FRAME_MAX) begin
          pos_nxt = lfmcd_pkg::POS_START;
        end else begin
          size_nxt = in_rx_byte;
          pos_nxt  = lfmcd_pkg::POS_BODY;
        end
      end else if (close) begin
        pos_nxt = lfmcd_pkg::POS_START;
      end else if (32'(pos_r) > FRAME_MAX) begin
        pos_nxt = lfmcd_pkg::POS_START;
      end else begin
        pos_nxt = pos_r + PW'(1);
      end
    end
    if (ID_IN && wr_en && (32'(pos_r) == ID_IDX)) begin
      id_nxt = in_rx_byte;
    end
  end

  // drive byte addresses follow the offsets as they will be after this edge
  assign ra_l     = RA_W'(DATA_OFFSET) + RA_W'(left_ofs_nxt);
  assign ra_r     = RA_W'(DATA_OFFSET) + RA_W'(right_ofs_nxt);
  assign ra_l_oor = (32'(ra_l) >= STORE_DEPTH);
  assign ra_r_oor = (32'(ra_r) >= STORE_DEPTH);

  // store write and registered reads
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= in_rx_byte;
    end
    rd_l_raw_r <= mem[ra_l[AW-1:0]];
    rd_r_raw_r <= mem[ra_r[AW-1:0]];
    wdat_r     <= in_rx_byte;
  end

  // read flags: bypass of a same-edge write, entry valid, address past the store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      byp_l_r <= 1'b0;
      byp_r_r <= 1'b0;
      vld_l_r <= 1'b0;
      vld_r_r <= 1'b0;
      oor_l_r <= 1'b0;
      oor_r_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_idx] <= 1'b1;
      end
      byp_l_r <= wr_en && (ra_l[AW-1:0] == wr_idx);
      byp_r_r <= wr_en && (ra_r[AW-1:0] == wr_idx);
      vld_l_r <= valid_r[ra_l[AW-1:0]];
      vld_r_r <= valid_r[ra_r[AW-1:0]];
      oor_l_r <= ra_l_oor;
      oor_r_r <= ra_r_oor;
    end
  end

  assign left_byte  = oor_l_r ? '0 : byp_l_r ? wdat_r : vld_l_r ? rd_l_raw_r : '0;
  assign right_byte = oor_r_r ? '0 : byp_r_r ? wdat_r : vld_r_r ? rd_r_raw_r : '0;

  // control and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      end_byte_r  <= '0;
      slot_id_r   <= '0;
      left_ofs_r  <= lfmcd_pkg::LEFT_OFFSET_RST;
      right_ofs_r <= lfmcd_pkg::RIGHT_OFFSET_RST;
      pos_r       <= lfmcd_pkg::POS_START;
      size_r      <= '0;
      id_r        <= '0;
    end else begin
      end_byte_r  <= end_byte_nxt;
      slot_id_r   <= slot_id_nxt;
      left_ofs_r  <= left_ofs_nxt;
      right_ofs_r <= right_ofs_nxt;
      pos_r       <= pos_nxt;
      size_r      <= size_nxt;
      id_r        <= id_nxt;
    end
  end

  // two-entry result queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (pop) begin
        skid_v_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_v_r || pop) begin
        out_v_r <= 1'b1;
      end else begin
        skid_v_r <= 1'b1;
      end
    end else if (pop) begin
      out_v_r <= 1'b0;
    end
  end

  // result payload, no reset
  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (pop) begin
        out_l_r  <= skid_l_r;
        out_rt_r <= skid_rt_r;
      end
    end else if (push) begin
      if (!out_v_r || pop) begin
        out_l_r  <= left_byte;
        out_rt_r <= right_byte;
      end else begin
        skid_l_r  <= left_byte;
        skid_rt_r <= right_byte;
      end
    end
  end

  assign out_valid       = out_v_r;
  assign out_left_drive  = out_l_r;
  assign out_right_drive = out_rt_r;

  // checks
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r) else $error("skid entry without result entry");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(pos_r) <= FRAME_MAX + 1) else $error("frame position out of range");

  a_size_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(size_r) <= FRAME_MAX) else $error("frame size above limit");

  a_start_skip: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && pos_r == lfmcd_pkg::POS_START) |=> (pos_r == lfmcd_pkg::POS_SIZE))
    else $error("start byte not skipped");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_ready) |=> out_v_r) else $error("waiting result lost");

endmodule
